@@ design/kbrp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kbrp_pkg
// shared constants and types of the keyed buffer recycle pool
// ----------------------------------------------------------------------------
package kbrp_pkg;

	localparam int ENTRIES     = 32;
	localparam int ALIGN       = 64;
	localparam int OWNER_BITS  = 8;
	localparam int HANDLE_BITS = 16;
	localparam int SIZE_W      = 15;
	localparam int COUNT_W     = $clog2(ENTRIES + 1);
	localparam int SIZE_SAT    = ((2 ** SIZE_W - 1) / ALIGN) * ALIGN;
	localparam int ADDR_W      = 3;

	localparam logic FUNC_OBTAIN  = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// word index of the enable register
	localparam logic REG_POOL_ENABLE = 1'b0;

	typedef struct packed {
		logic                   func;
		logic [OWNER_BITS-1:0]  owner;
		logic [SIZE_W-1:0]      width;
		logic [SIZE_W-1:0]      height;
		logic [HANDLE_BITS-1:0] handle;
	} kbrp_req_t;

	typedef struct packed {
		logic                   hit;
		logic [HANDLE_BITS-1:0] handle;
		logic                   evict;
		logic [HANDLE_BITS-1:0] evict_handle;
	} kbrp_rsp_t;

endpackage
`default_nettype wire

@@ design/kbrp_round.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kbrp_round
// rounds a size up to the alignment, saturating at the largest aligned size
// ----------------------------------------------------------------------------
module kbrp_round (
	input  wire logic [kbrp_pkg::SIZE_W-1:0] size,
	output logic      [kbrp_pkg::SIZE_W-1:0] rounded
);
	import kbrp_pkg::*;

	logic [SIZE_W:0] sum;
	logic [SIZE_W:0] trunc;

	assign sum   = {1'b0, size} + (SIZE_W + 1)'(ALIGN - 1);
	assign trunc = sum & ~((SIZE_W + 1)'(ALIGN - 1));

	always_comb begin
		if (trunc[SIZE_W]) begin
			rounded = SIZE_W'(SIZE_SAT);
		end else begin
			rounded = trunc[SIZE_W-1:0];
		end
	end

endmodule
`default_nettype wire

@@ design/kbrp_slots.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kbrp_slots
// slot storage with parallel key match, age matrix and oldest-entry select
// ----------------------------------------------------------------------------
module kbrp_slots (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         go,
	input  wire logic                         enable,
	input  wire kbrp_pkg::kbrp_req_t          req,
	input  wire logic [kbrp_pkg::SIZE_W-1:0]  rnd_width,
	input  wire logic [kbrp_pkg::SIZE_W-1:0]  rnd_height,
	output kbrp_pkg::kbrp_rsp_t               rsp
);
	import kbrp_pkg::*;

	logic [ENTRIES-1:0]     valid_q;
	logic [COUNT_W-1:0]     count_q;
	logic [OWNER_BITS-1:0]  owner_q  [ENTRIES];
	logic [SIZE_W-1:0]      width_q  [ENTRIES];
	logic [SIZE_W-1:0]      height_q [ENTRIES];
	logic [HANDLE_BITS-1:0] handle_q [ENTRIES];
	// older_q[i][j] set: slot j was released before slot i
	logic [ENTRIES-1:0]     older_q  [ENTRIES];

	logic [ENTRIES-1:0]     match;
	logic [ENTRIES-1:0]     hit_oh;
	logic [ENTRIES-1:0]     oldest_oh;
	logic [ENTRIES-1:0]     free_oh;
	logic [HANDLE_BITS-1:0] hit_handle;
	logic [HANDLE_BITS-1:0] old_handle;
	logic                   has_free;
	logic                   hit;
	logic                   do_insert;
	logic                   do_evict;
	logic                   bypass;

	always_comb begin
		hit_handle = '0;
		old_handle = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (owner_q[i] == req.owner) &&
				(width_q[i] == rnd_width) && (height_q[i] == rnd_height);
		end
		for (int i = 0; i < ENTRIES; i++) begin
			hit_oh[i]    = match[i] && !(|(match & older_q[i]));
			oldest_oh[i] = valid_q[i] && !(|(valid_q & older_q[i]));
			hit_handle   = hit_handle | (handle_q[i] & {HANDLE_BITS{hit_oh[i]}});
			old_handle   = old_handle | (handle_q[i] & {HANDLE_BITS{oldest_oh[i]}});
		end
	end

	// lowest clear bit of the valid vector
	assign free_oh   = ~valid_q & (valid_q + ENTRIES'(1));
	assign has_free  = ~&valid_q;

	assign hit       = enable && (req.func == FUNC_OBTAIN) && (|hit_oh);
	assign do_insert = enable && (req.func == FUNC_RELEASE) && has_free;
	assign do_evict  = do_insert && (count_q == COUNT_W'(ENTRIES - 1));
	assign bypass    = (req.func == FUNC_RELEASE) && !do_insert;

	always_comb begin
		rsp.hit          = hit;
		rsp.handle       = hit ? hit_handle : '0;
		rsp.evict        = do_evict || bypass;
		rsp.evict_handle = do_evict ? old_handle : (bypass ? req.handle : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (go) begin
			if (hit) begin
				valid_q <= valid_q & ~hit_oh;
				count_q <= count_q - COUNT_W'(1);
			end else if (do_insert) begin
				if (do_evict) begin
					valid_q <= (valid_q | free_oh) & ~oldest_oh;
				end else begin
					valid_q <= valid_q | free_oh;
					count_q <= count_q + COUNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && do_insert) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (free_oh[i]) begin
					owner_q[i]  <= req.owner;
					width_q[i]  <= req.width;
					height_q[i] <= req.height;
					handle_q[i] <= req.handle;
					older_q[i]  <= valid_q;
				end else begin
					older_q[i]  <= older_q[i] & ~free_oh;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ design/keyed_buffer_recycle_pool.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_buffer_recycle_pool
// recycle pool for buffer handles keyed by owner and aligned size
// ----------------------------------------------------------------------------
// result path: an accepted input transaction passes through the input register,
//   then the result register, which drives the master side
// throughput: one transaction per cycle while the master side does not stall,
//   set by the combinational match and oldest-entry select over the slot registers
// reset: pool empty (all slots invalid, count zero), pool_enable set to 1;
//   slot payload is not cleared and needs no sweep
module keyed_buffer_recycle_pool (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// slave side
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// owner_id[7:0], width[22:8], height[37:23], handle_in[53:38], zero pad
	input  wire logic [55:0]                 s_tdata,
	// func[0]
	input  wire logic [0:0]                  s_tuser,
	// master side
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// hit[0], handle_out[16:1], alloc_width[31:17], alloc_height[46:32],
	// evict_valid[47], evict_handle[63:48]
	output logic [63:0]                      m_tdata,
	// configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [kbrp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import kbrp_pkg::*;

	logic               enable_q;
	logic               valid_s1;
	kbrp_req_t          req_s1;
	logic               valid_s2;
	logic [63:0]        data_s2;
	logic               adv;
	logic [SIZE_W-1:0]  rnd_width;
	logic [SIZE_W-1:0]  rnd_height;
	kbrp_rsp_t          rsp;
	logic               miss;
	logic [63:0]        result;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (psel && penable && pwrite && (paddr[2] == REG_POOL_ENABLE)) begin
			enable_q <= pwdata[0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_POOL_ENABLE: prdata = {31'b0, enable_q};
			default:         prdata = '0;
		endcase
	end

	// input register
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.func   <= s_tuser[0];
			req_s1.owner  <= s_tdata[7:0];
			req_s1.width  <= s_tdata[22:8];
			req_s1.height <= s_tdata[37:23];
			req_s1.handle <= s_tdata[53:38];
		end
	end

	kbrp_round u_round_w (
		.size    (req_s1.width),
		.rounded (rnd_width)
	);

	kbrp_round u_round_h (
		.size    (req_s1.height),
		.rounded (rnd_height)
	);

	kbrp_slots u_slots (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (adv),
		.enable     (enable_q),
		.req        (req_s1),
		.rnd_width  (rnd_width),
		.rnd_height (rnd_height),
		.rsp        (rsp)
	);

	assign miss   = (req_s1.func == FUNC_OBTAIN) && !rsp.hit;
	assign result = {rsp.evict_handle,
		rsp.evict,
		miss ? rnd_height : {SIZE_W{1'b0}},
		miss ? rnd_width : {SIZE_W{1'b0}},
		rsp.handle,
		rsp.hit};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

endmodule
`default_nettype wire
